// ===== hdl/fbd_pkg.sv =====
`default_nettype none

package fbd_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam int NUM_ENTRIES = 4;
  localparam int ENTRY_W     = 34;
  localparam int FCC_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = ENTRY_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL   = 3'd4;

  localparam logic [ENTRY_W-1:0] ENTRY0_RST = 34'h1676E6970;
  localparam logic [ENTRY_W-1:0] ENTRY1_RST = 34'h26B6E6973;
  localparam logic [31:0]        STALL_RST  = 32'd2000;

  localparam logic [3:0] HDR_LEN  = 4'd8;
  localparam logic [3:0] HDR_LAST = 4'd7;

  // input item kinds
  localparam logic IN_BYTE = 1'b0;
  localparam logic IN_TICK = 1'b1;

  // table entry kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_STREAM = 2'd2;

  // result events
  localparam logic [2:0] EV_UNKNOWN  = 3'd0;
  localparam logic [2:0] EV_DONE     = 3'd1;
  localparam logic [2:0] EV_TOO_BIG  = 3'd2;
  localparam logic [2:0] EV_CMD_BYTE = 3'd3;
  localparam logic [2:0] EV_START    = 3'd4;
  localparam logic [2:0] EV_STR_BYTE = 3'd5;
  localparam logic [2:0] EV_STALLED  = 3'd6;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } fbd_store_req_t;

endpackage

`default_nettype wire

// ===== hdl/fbd_if.sv =====
`default_nettype none

interface fbd_in_if;
  import fbd_pkg::*;

  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface fbd_out_if;
  import fbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       event_res;
  logic [1:0]       entry_index;
  logic [FCC_W-1:0] fourcc_code;
  logic [31:0]      payload_length;
  logic [7:0]       out_byte;
  logic             last;

  modport source (output valid, output event_res, output entry_index, output fourcc_code,
                  output payload_length, output out_byte, output last, input ready);
  modport sink   (input valid, input event_res, input entry_index, input fourcc_code,
                  input payload_length, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/fbd_store.sv =====
`default_nettype none

module fbd_store (
  input  logic                    clk,
  input  fbd_pkg::fbd_store_req_t req,
  output logic [7:0]              rdata
);
  import fbd_pkg::*;

  logic [7:0] mem [MAX_PAYLOAD];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fourcc_box_deframer.sv =====
`default_nettype none

// Box deframer: takes one byte or tick item per cycle while not held off and answers each
// with at most one result item, except at the end of a command box of 1 to MAX_PAYLOAD
// bytes. There the done result is followed by a readout of the buffered payload from the
// payload memory: each byte passes an address state, then a registered read data state,
// so input is held off for the whole readout, which runs longer while the output side
// stalls. Results wait in an output register; input keeps flowing while the output side
// stalls as long as that register is empty or being taken.
// The payload memory needs no clearing after reset: only bytes of the current box are read.
module fourcc_box_deframer (
  input  logic                              clk,
  input  logic                              rst,
  fbd_in_if.sink                            in_ch,
  fbd_out_if.source                         out_ch,
  input  logic                              wr_en,
  input  logic [fbd_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [fbd_pkg::CFG_DATA_W-1:0]    wr_data
);
  import fbd_pkg::*;

  localparam logic [1:0] ST_IN    = 2'd0;
  localparam logic [1:0] ST_RADDR = 2'd1;
  localparam logic [1:0] ST_RDATA = 2'd2;

  logic [ENTRY_W-1:0] entries [NUM_ENTRIES];
  logic [31:0]        stall_ticks;

  logic [1:0]        state, state_next;
  logic [63:0]       header_bytes, header_bytes_next;
  logic [3:0]        header_count, header_count_next;
  logic [31:0]       payload_count, payload_count_next;
  logic [31:0]       idle_count, idle_count_next;
  logic [1:0]        match_index, match_index_next;
  logic [1:0]        match_kind, match_kind_next;
  logic [ADDR_W-1:0] rd_idx, rd_idx_next;

  logic             out_valid;
  logic [2:0]       out_event;
  logic [1:0]       out_index;
  logic [FCC_W-1:0] out_fcc;
  logic [31:0]      out_len;
  logic [7:0]       out_data;
  logic             out_last;

  logic           out_free, accept, load_out;
  logic [2:0]     ld_event;
  logic [1:0]     ld_index;
  logic [7:0]     ld_data;
  logic           ld_last;
  logic [63:0]    hdr;
  logic [1:0]     m_kind, m_index;
  logic [1:0]     e_kind;
  logic [31:0]    idle_inc, pc_inc, len;
  logic           rd_end;
  fbd_store_req_t store_req;
  logic [7:0]     store_rdata;

  fbd_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IN) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rd_end      = (({1'b0, rd_idx} + (ADDR_W+1)'(1)) == header_bytes[ADDR_W:0]);

  // header assembly and table lookup; the first matching entry wins
  always_comb begin
    hdr = (header_count == '0) ? 64'd0 : header_bytes;
    hdr[{header_count[2:0], 3'b000} +: 8] = in_ch.data_byte;
    m_kind  = KIND_NONE;
    m_index = 2'd0;
    e_kind  = KIND_NONE;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      e_kind = entries[i][ENTRY_W-1:FCC_W];
      if ((e_kind == KIND_CMD || e_kind == KIND_STREAM) &&
          entries[i][FCC_W-1:0] == hdr[63:32]) begin
        m_kind  = e_kind;
        m_index = 2'(i);
      end
    end
  end

  always_comb begin
    state_next         = state;
    header_bytes_next  = header_bytes;
    header_count_next  = header_count;
    payload_count_next = payload_count;
    idle_count_next    = idle_count;
    match_index_next   = match_index;
    match_kind_next    = match_kind;
    rd_idx_next        = rd_idx;
    load_out           = 1'b0;
    ld_event           = EV_UNKNOWN;
    ld_index           = 2'd0;
    ld_data            = 8'd0;
    ld_last            = 1'b1;
    store_req          = '0;
    idle_inc           = (idle_count == '1) ? idle_count : idle_count + 32'd1;
    pc_inc             = payload_count + 32'd1;
    len                = header_bytes[31:0];

    case (state)
      ST_IN: begin
        if (accept) begin
          if (in_ch.kind == IN_TICK) begin
            if (header_count != '0) begin
              idle_count_next = idle_inc;
              if (idle_inc > stall_ticks) begin
                load_out           = 1'b1;
                ld_event           = EV_STALLED;
                header_count_next  = '0;
                payload_count_next = '0;
                idle_count_next    = '0;
              end
            end
          end else begin
            idle_count_next = '0;
            if (header_count < HDR_LEN) begin
              header_bytes_next = hdr;
              header_count_next = header_count + 4'd1;
              if (header_count == HDR_LAST) begin
                len                = hdr[31:0];
                match_kind_next    = m_kind;
                match_index_next   = m_index;
                payload_count_next = '0;
                if (m_kind == KIND_NONE) begin
                  load_out = 1'b1;
                  ld_event = EV_UNKNOWN;
                end else if (m_kind == KIND_STREAM) begin
                  load_out = 1'b1;
                  ld_event = EV_START;
                  ld_index = m_index;
                end else if (len == '0) begin
                  load_out = 1'b1;
                  ld_event = EV_DONE;
                  ld_index = m_index;
                end
                if (len == '0) begin
                  header_count_next = '0;
                end
              end
            end else begin
              // payload byte
              if (match_kind != KIND_STREAM && payload_count < 32'(MAX_PAYLOAD)) begin
                store_req.we    = 1'b1;
                store_req.waddr = payload_count[ADDR_W-1:0];
                store_req.wdata = in_ch.data_byte;
              end
              payload_count_next = pc_inc;
              if (match_kind == KIND_STREAM) begin
                load_out = 1'b1;
                ld_event = EV_STR_BYTE;
                ld_index = match_index;
                ld_data  = in_ch.data_byte;
              end
              if (pc_inc >= len) begin
                header_count_next  = '0;
                payload_count_next = '0;
                if (match_kind == KIND_CMD) begin
                  load_out = 1'b1;
                  ld_index = match_index;
                  if (len > 32'(MAX_PAYLOAD)) begin
                    ld_event = EV_TOO_BIG;
                  end else begin
                    // done, then read the buffered bytes back out
                    ld_event    = EV_DONE;
                    ld_last     = 1'b0;
                    state_next  = ST_RADDR;
                    rd_idx_next = '0;
                  end
                end
              end
            end
          end
        end
      end
      ST_RADDR: begin
        store_req.re    = 1'b1;
        store_req.raddr = rd_idx;
        state_next      = ST_RDATA;
      end
      ST_RDATA: begin
        if (out_free) begin
          load_out = 1'b1;
          ld_event = EV_CMD_BYTE;
          ld_index = match_index;
          ld_data  = store_rdata;
          ld_last  = rd_end;
          if (rd_end) begin
            state_next = ST_IN;
          end else begin
            rd_idx_next = rd_idx + ADDR_W'(1);
            state_next  = ST_RADDR;
          end
        end
      end
      default: begin
        state_next = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries[0]  <= ENTRY0_RST;
      entries[1]  <= ENTRY1_RST;
      entries[2]  <= '0;
      entries[3]  <= '0;
      stall_ticks <= STALL_RST;
    end else if (wr_en) begin
      if (wr_index == CFG_STALL) begin
        stall_ticks <= wr_data[31:0];
      end else if (wr_index < CFG_STALL && wr_index >= CFG_ENTRY_0) begin
        entries[wr_index[1:0]] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IN;
      header_bytes  <= '0;
      header_count  <= '0;
      payload_count <= '0;
      idle_count    <= '0;
      match_index   <= '0;
      match_kind    <= KIND_NONE;
      rd_idx        <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      header_bytes  <= header_bytes_next;
      header_count  <= header_count_next;
      payload_count <= payload_count_next;
      idle_count    <= idle_count_next;
      match_index   <= match_index_next;
      match_kind    <= match_kind_next;
      rd_idx        <= rd_idx_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_event <= ld_event;
      out_index <= ld_index;
      out_fcc   <= header_bytes_next[63:32];
      out_len   <= header_bytes_next[31:0];
      out_data  <= ld_data;
      out_last  <= ld_last;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.event_res      = out_event;
  assign out_ch.entry_index    = out_index;
  assign out_ch.fourcc_code    = out_fcc;
  assign out_ch.payload_length = out_len;
  assign out_ch.out_byte       = out_data;
  assign out_ch.last           = out_last;

  // no input while the payload readout runs
  a_no_input_in_readout: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IN) |-> !in_ch.ready)
    else $error("input accepted during payload readout");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !load_out)
    else $error("output register overwritten");

  a_header_count_range: assert property (@(posedge clk) disable iff (rst)
    header_count <= HDR_LEN)
    else $error("header count out of range");

  // buffered bytes only come from boxes that fit the store
  a_cmd_byte_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_event == EV_CMD_BYTE) |->
      (out_len <= 32'(MAX_PAYLOAD) && out_len != '0))
    else $error("command byte from a box that does not fit");

  // a readout ends with a last-marked byte before input resumes
  a_readout_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDATA && state_next == ST_IN) |-> (load_out && ld_last))
    else $error("readout left without a final byte");

endmodule

`default_nettype wire
